>>> rtl/mbrx_pkg.sv
// Shared types and constants for the Modbus RTU frame receiver.
// No dependencies; used by every module under rtl/.
`default_nettype none

package mbrx_pkg;

  localparam int unsigned MaxFrameDef = 256;
  localparam int unsigned CntW = 9;
  localparam logic [15:0] SilenceTicksRst = 16'd35;
  localparam logic [15:0] CrcPreset = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [CntW-1:0] MinFrameLen = 9'd4;
  localparam logic [CntW-1:0] FrameOverhead = 9'd3;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_BYTE  = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_BYTE    = 3'd1,
    EV_BUS_RDY = 3'd2,
    EV_VALID   = 3'd3,
    EV_REJECT  = 3'd4
  } event_e;

  localparam logic [1:0] ModeInit  = 2'd0;
  localparam logic [1:0] ModeIdle  = 2'd1;
  localparam logic [1:0] ModeRcv   = 2'd2;
  localparam logic [1:0] ModeError = 2'd3;

  typedef struct packed {
    op_e        op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    event_e     event_res;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] slave_address;
    logic [7:0] pdu_length;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/mbrx_crc.sv
// Byte-wide Modbus CRC-16 update (reflected poly, eight shift steps).
// Depends on mbrx_pkg.
`default_nettype none

module mbrx_crc (
  input  wire logic [15:0] crc_i,
  input  wire logic [7:0]  byte_i,
  output logic      [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, byte_i};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ mbrx_pkg::CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

`default_nettype wire

>>> rtl/mbrx_core.sv
// Receiver state (mode, silence timer, byte count, running CRC) and the
// per-beat result logic. Depends on mbrx_pkg and mbrx_crc.
`default_nettype none

module mbrx_core #(
  parameter int unsigned MaxFrame = mbrx_pkg::MaxFrameDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [15:0]         cfg_wdata_i,
  input  wire logic                step_i,
  input  wire mbrx_pkg::in_item_t  item_i,
  output mbrx_pkg::out_item_t      res_o
);

  localparam logic [mbrx_pkg::CntW-1:0] FrameLimit = mbrx_pkg::CntW'(MaxFrame);

  logic [15:0] silence_ticks_q;
  logic [1:0]  mode_q, mode_d;
  logic        enabled_q, enabled_d;
  logic        timer_q, timer_d;
  logic [15:0] scount_q, scount_d;
  logic [mbrx_pkg::CntW-1:0] bcount_q, bcount_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  first_q, first_d;

  logic [15:0] crc_base, crc_next, scount_inc, limit;
  logic [mbrx_pkg::CntW-1:0] plen_full;

  assign crc_base = (mode_q == mbrx_pkg::ModeIdle) ? mbrx_pkg::CrcPreset : crc_q;
  assign scount_inc = scount_q + 16'd1;
  assign limit = (silence_ticks_q == 16'd0) ? 16'd1 : silence_ticks_q;
  assign plen_full = bcount_q - mbrx_pkg::FrameOverhead;

  mbrx_crc u_crc (
    .crc_i  (crc_base),
    .byte_i (item_i.rx_byte),
    .crc_o  (crc_next)
  );

  always_comb begin
    mode_d    = mode_q;
    enabled_d = enabled_q;
    timer_d   = timer_q;
    scount_d  = scount_q;
    bcount_d  = bcount_q;
    crc_d     = crc_q;
    first_d   = first_q;
    res_o     = '0;
    res_o.event_res = mbrx_pkg::EV_NONE;
    unique case (item_i.op)
      mbrx_pkg::OP_START: begin
        mode_d    = mbrx_pkg::ModeInit;
        enabled_d = 1'b1;
        timer_d   = 1'b1;
        scount_d  = '0;
      end
      mbrx_pkg::OP_STOP: begin
        enabled_d = 1'b0;
        timer_d   = 1'b0;
        scount_d  = '0;
      end
      mbrx_pkg::OP_BYTE: begin
        if (enabled_q) begin
          timer_d  = 1'b1;
          scount_d = '0;
          if (mode_q == mbrx_pkg::ModeIdle) begin
            crc_d    = crc_next;
            first_d  = item_i.rx_byte;
            bcount_d = mbrx_pkg::CntW'(1);
            mode_d   = mbrx_pkg::ModeRcv;
            res_o.event_res = mbrx_pkg::EV_BYTE;
            res_o.data_byte = item_i.rx_byte;
          end else if (mode_q == mbrx_pkg::ModeRcv) begin
            if (bcount_q < FrameLimit) begin
              crc_d    = crc_next;
              bcount_d = bcount_q + mbrx_pkg::CntW'(1);
              res_o.event_res  = mbrx_pkg::EV_BYTE;
              res_o.data_byte  = item_i.rx_byte;
              res_o.byte_index = bcount_q[7:0];
            end else begin
              mode_d = mbrx_pkg::ModeError;
            end
          end
        end
      end
      mbrx_pkg::OP_TICK: begin
        if (timer_q) begin
          scount_d = scount_inc;
          if (scount_inc >= limit) begin
            if (mode_q == mbrx_pkg::ModeInit) begin
              res_o.event_res = mbrx_pkg::EV_BUS_RDY;
            end else if (mode_q == mbrx_pkg::ModeRcv) begin
              if (bcount_q >= mbrx_pkg::MinFrameLen && crc_q == 16'd0) begin
                res_o.event_res     = mbrx_pkg::EV_VALID;
                res_o.slave_address = first_q;
                res_o.pdu_length    = plen_full[7:0];
              end else begin
                res_o.event_res = mbrx_pkg::EV_REJECT;
              end
            end
            timer_d  = 1'b0;
            scount_d = '0;
            mode_d   = mbrx_pkg::ModeIdle;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      silence_ticks_q <= mbrx_pkg::SilenceTicksRst;
      mode_q    <= mbrx_pkg::ModeInit;
      enabled_q <= 1'b0;
      timer_q   <= 1'b0;
      scount_q  <= '0;
      bcount_q  <= '0;
      crc_q     <= mbrx_pkg::CrcPreset;
      first_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        silence_ticks_q <= cfg_wdata_i;
      end
      if (step_i) begin
        mode_q    <= mode_d;
        enabled_q <= enabled_d;
        timer_q   <= timer_d;
        scount_q  <= scount_d;
        bcount_q  <= bcount_d;
        crc_q     <= crc_d;
        first_q   <= first_d;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/modbus_rtu_frame_receiver_unit.sv
// Modbus RTU frame receiver top level: input register, receiver core and
// result register. Depends on mbrx_pkg and mbrx_core.
`default_nettype none

// Takes one event beat (start, stop, received byte, timer tick) per clock
// unless stalled, and returns exactly one result beat for each, in order. A
// beat passes through the input register and then the result register, with
// the state update and byte CRC done combinationally between them. The result
// register stalls back to the input register and from there to in_stall_o.
// silence_ticks is written through cfg_we_i and cfg_wdata_i by the user only
// while no beat is in flight; the block does not enforce this. It resets to 35.
module modbus_rtu_frame_receiver_unit #(
  parameter int unsigned MaxFrame = mbrx_pkg::MaxFrameDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [15:0]          cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire mbrx_pkg::in_item_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output mbrx_pkg::out_item_t       out_data_o
);

  logic                s0_valid_q;
  mbrx_pkg::in_item_t  s0_item_q;
  logic                s1_valid_q;
  mbrx_pkg::out_item_t s1_res_q;
  mbrx_pkg::out_item_t res;
  logic                s1_free, s0_move, s0_free;

  assign s1_free = !s1_valid_q || !out_stall_i;
  assign s0_move = s0_valid_q && s1_free;
  assign s0_free = !s0_valid_q || s1_free;
  assign in_stall_o = !s0_free;

  mbrx_core #(
    .MaxFrame (MaxFrame)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (s0_move),
    .item_i      (s0_item_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      if (s0_free) begin
        s0_valid_q <= in_valid_i;
      end
      if (s1_free) begin
        s1_valid_q <= s0_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_free && in_valid_i) begin
      s0_item_q <= in_data_i;
    end
    if (s0_move) begin
      s1_res_q <= res;
    end
  end

  assign out_valid_o = s1_valid_q;
  assign out_data_o  = s1_res_q;

endmodule

`default_nettype wire

>>> verif/tb.sv
// Testbench for modbus_rtu_frame_receiver_unit: directed and random event streams,
// checked beat by beat against an in-bench model of the receiver.
// Depends on mbrx_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module tb;
  import mbrx_pkg::*;

  localparam int unsigned WdogLimit = 3000;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;

  modbus_rtu_frame_receiver_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // receiver model state
  logic [15:0] m_silence_ticks = SilenceTicksRst;
  logic [1:0]  m_mode = ModeInit;
  logic        m_enabled = 1'b0;
  logic        m_timer_on = 1'b0;
  logic [15:0] m_silence_cnt = '0;
  logic [8:0]  m_byte_cnt = '0;
  logic [15:0] m_crc = CrcPreset;
  logic [7:0]  m_first_byte = '0;

  out_item_t pending_events[$];
  int        err_cnt = 0;
  int        items_sent = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        wdog_cnt = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    return c;
  endfunction

  function automatic int tick_limit();
    return (m_silence_ticks == 0) ? 1 : int'(m_silence_ticks);
  endfunction

  function automatic out_item_t next_event(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.op)
      OP_START: begin
        m_mode = ModeInit;
        m_enabled = 1'b1;
        m_timer_on = 1'b1;
        m_silence_cnt = '0;
      end
      OP_STOP: begin
        m_enabled = 1'b0;
        m_timer_on = 1'b0;
        m_silence_cnt = '0;
      end
      OP_BYTE: begin
        if (m_enabled) begin
          if (m_mode == ModeIdle) begin
            m_crc = crc16_byte(CrcPreset, it.rx_byte);
            m_first_byte = it.rx_byte;
            m_byte_cnt = 9'd1;
            m_mode = ModeRcv;
            r.event_res = EV_BYTE;
            r.data_byte = it.rx_byte;
          end else if (m_mode == ModeRcv) begin
            if (m_byte_cnt < MaxFrameDef) begin
              m_crc = crc16_byte(m_crc, it.rx_byte);
              r.event_res = EV_BYTE;
              r.data_byte = it.rx_byte;
              r.byte_index = m_byte_cnt[7:0];
              m_byte_cnt = m_byte_cnt + 9'd1;
            end else begin
              m_mode = ModeError;
            end
          end
          m_timer_on = 1'b1;
          m_silence_cnt = '0;
        end
      end
      OP_TICK: begin
        if (m_timer_on) begin
          m_silence_cnt = m_silence_cnt + 16'd1;
          if (m_silence_cnt >= tick_limit()) begin
            if (m_mode == ModeInit) begin
              r.event_res = EV_BUS_RDY;
            end else if (m_mode == ModeRcv) begin
              if (m_byte_cnt >= MinFrameLen && m_crc == 16'd0) begin
                r.event_res = EV_VALID;
                r.slave_address = m_first_byte;
                r.pdu_length = 8'(m_byte_cnt - FrameOverhead);
              end else begin
                r.event_res = EV_REJECT;
              end
            end
            m_timer_on = 1'b0;
            m_silence_cnt = '0;
            m_mode = ModeIdle;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_beat(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    pending_events.push_back(next_event(it));
    items_sent++;
  endtask

  task automatic send_op(op_e op, logic [7:0] b);
    in_item_t it;
    it.op = op;
    it.rx_byte = b;
    send_beat(it);
  endtask

  task automatic send_ticks(int n);
    for (int i = 0; i < n; i++) send_op(OP_TICK, 8'($urandom_range(255)));
  endtask

  // good frames of three or more bytes end in their CRC, low byte first, so the residue is zero
  task automatic send_frame(int len, bit good);
    logic [15:0] crc;
    logic [15:0] fcs;
    logic [7:0]  b;
    crc = CrcPreset;
    fcs = '0;
    for (int i = 0; i < len; i++) begin
      if (good && len >= 3 && i == len - 2) begin
        fcs = crc;
        b = fcs[7:0];
      end else if (good && len >= 3 && i == len - 1) begin
        b = fcs[15:8];
      end else begin
        b = 8'($urandom_range(255));
      end
      crc = crc16_byte(crc, b);
      send_op(OP_BYTE, b);
    end
  endtask

  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_silence(logic [15:0] v);
    settle_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    m_silence_ticks = v;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      err_cnt++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        err_cnt++;
        $error("result beat with nothing pending: event_res %0d", out_data_o.event_res);
      end else begin
        want = pending_events.pop_front();
        check_field("event_res", want.event_res, out_data_o.event_res);
        check_field("data_byte", want.data_byte, out_data_o.data_byte);
        check_field("byte_index", want.byte_index, out_data_o.byte_index);
        check_field("slave_address", want.slave_address, out_data_o.slave_address);
        check_field("pdu_length", want.pdu_length, out_data_o.pdu_length);
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) wdog_cnt <= 0;
    else wdog_cnt <= wdog_cnt + 1;
    if (wdog_cnt >= WdogLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // reset value of silence_ticks, disabled and stopped-timer behavior
  task automatic test_reset_defaults();
    send_op(OP_BYTE, 8'hA5);
    send_op(OP_TICK, 8'h5A);
    send_op(OP_STOP, 8'h00);
    send_op(OP_START, 8'hFF);
    send_op(OP_BYTE, 8'h3C);
    send_ticks(int'(SilenceTicksRst));
    send_op(OP_TICK, 8'h00);
  endtask

  task automatic test_directed();
    write_silence(16'd2);
    send_op(OP_START, 8'h00);
    send_ticks(2);
    send_op(OP_TICK, 8'hFF);
    send_op(OP_BYTE, 8'h00);
    send_op(OP_BYTE, 8'hFF);
    send_frame(2, 1'b0);
    send_ticks(2);
    send_frame(4, 1'b1);
    send_ticks(2);
    send_op(OP_BYTE, 8'hFF);
    send_op(OP_BYTE, 8'h03);
    send_op(OP_BYTE, 8'h00);
    send_op(OP_BYTE, 8'h00);
    send_ticks(2);
    send_frame(3, 1'b1);
    send_ticks(2);
    send_frame(2, 1'b1);
    send_op(OP_TICK, 8'h00);
    send_frame(3, 1'b1);
    send_op(OP_STOP, 8'h00);
    send_op(OP_BYTE, 8'h77);
    send_op(OP_TICK, 8'h00);
    send_op(OP_START, 8'h00);
    send_op(OP_BYTE, 8'h81);
    send_ticks(2);
  endtask

  task automatic test_zero_silence();
    write_silence(16'd0);
    send_op(OP_START, 8'h00);
    send_op(OP_TICK, 8'h00);
    send_frame(6, 1'b1);
    send_op(OP_TICK, 8'h00);
    send_frame(1, 1'b0);
    send_op(OP_TICK, 8'h00);
  endtask

  // full-length frames and overflow into the error state
  task automatic test_long_frames();
    write_silence(16'd1);
    send_op(OP_START, 8'h00);
    send_op(OP_TICK, 8'h00);
    send_frame(MaxFrameDef, 1'b1);
    send_op(OP_TICK, 8'h00);
    send_frame(MaxFrameDef + 1, 1'b1);
    send_op(OP_BYTE, 8'h12);
    send_op(OP_TICK, 8'h00);
    send_frame(MaxFrameDef, 1'b0);
    send_op(OP_TICK, 8'h00);
    send_frame(5, 1'b1);
    send_op(OP_TICK, 8'h00);
  endtask

  task automatic test_max_silence();
    write_silence(16'hFFFF);
    send_op(OP_START, 8'h00);
    send_ticks(8);
    send_op(OP_STOP, 8'h00);
    send_op(OP_TICK, 8'h00);
  endtask

  task automatic test_random(int idle, int stall, int n, logic [15:0] ticks);
    int stop_at;
    int kind;
    write_silence(ticks);
    idle_pct = idle;
    stall_pct = stall;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 91 && !m_enabled) send_op(OP_START, 8'($urandom_range(255)));
      if (kind < 85 && m_timer_on) send_ticks(tick_limit());
      if (kind < 55) begin
        send_frame($urandom_range(4, 12), 1'b1);
        send_ticks(tick_limit() + $urandom_range(2));
      end else if (kind < 68) begin
        send_frame($urandom_range(1, 8), 1'b0);
        send_ticks(tick_limit());
      end else if (kind < 78) begin
        send_frame($urandom_range(1, 5), 1'b1);
        if (tick_limit() > 1) send_ticks($urandom_range(1, tick_limit() - 1));
        send_frame($urandom_range(1, 6), 1'($urandom_range(1)));
        send_ticks(tick_limit());
      end else if (kind < 85) begin
        send_frame($urandom_range(1, 6), 1'b1);
        send_op(OP_STOP, 8'($urandom_range(255)));
        send_frame($urandom_range(3), 1'b0);
        send_ticks($urandom_range(2));
        send_op(OP_START, 8'($urandom_range(255)));
        send_ticks(tick_limit());
      end else if (kind < 91) begin
        send_op(OP_START, 8'($urandom_range(255)));
        send_ticks($urandom_range(tick_limit() + 1));
      end else begin
        repeat ($urandom_range(1, 6))
          send_op(op_e'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed();
    test_zero_silence();
    test_long_frames();
    test_max_silence();
    test_random(0, 0, 65, 16'd1);
    test_random(86, 0, 65, 16'd3);
    test_random(0, 86, 65, 16'd2);
    test_random(14, 14, 55, 16'd4);
    settle_idle();
    if (err_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

>>> modbus_rtu_frame_receiver_unit.f
rtl/mbrx_pkg.sv
rtl/mbrx_crc.sv
rtl/mbrx_core.sv
rtl/modbus_rtu_frame_receiver_unit.sv
verif/tb.sv
